FILE: src/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types, sizes and codes of the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

    localparam int NUM_TABLES = 16;
    localparam int MAX_POINTS = 32;

    localparam int DEPTH  = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TBL_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int TID_W  = 4;
    localparam int VAL_W  = 32;
    localparam int DCNT_W = 5;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_LAST   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] d;
        logic [VAL_W-1:0]        c;
        logic [VAL_W-1:0]        g;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    typedef enum logic [1:0] {
        ADDR_WR,
        ADDR_LASTPT,
        ADDR_FIRSTPT,
        ADDR_IDX
    } addr_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_FULL,
        RES_RAM,
        RES_FIRST,
        RES_LERP
    } res_sel_t;

    typedef struct packed {
        logic      latch;
        logic      ram_we;
        logic      ram_re;
        addr_sel_t addr_sel;
        logic      cnt_inc;
        logic      cnt_clr;
        logic      idx_init;
        logic      idx_inc;
        logic      cap_first;
        logic      cap_prev;
        logic      cap_cur;
        logic      half;
        logic      mul_go;
        logic      div_init;
        logic      div_step;
        logic      lerp_save;
        logic      res_go;
        res_sel_t  res_sel;
    } pti_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       absent;
        logic       n_zero;
        logic       n_one;
        logic       n_full;
        logic       neg;
        logic       bracket;
        logic       last_idx;
        logic       at_first;
        logic       div_last;
    } pti_stat_t;

endpackage

FILE: src/pti_ram.sv
// ----------------------------------------------------------------------------
// pti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pti_ctrl.sv
// ----------------------------------------------------------------------------
// pti_ctrl
// Sequencer: decodes a command word, walks the table and, on a bracket, runs two interpolations.
// ----------------------------------------------------------------------------
module pti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pti_pkg::pti_stat_t stat,
    output pti_pkg::pti_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PT_WAIT,
        S_FIRST_WAIT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   half_reg, half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        cmd        = '0;
        cmd.half   = half_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (stat.absent)
                begin
                    cmd.res_go  = 1'b1;
                    cmd.res_sel = pti_pkg::RES_EMPTY;
                end
                else if (stat.op == pti_pkg::OP_APPEND)
                begin
                    cmd.res_go = 1'b1;
                    if (stat.n_full)
                    begin
                        cmd.res_sel = pti_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.ram_we   = 1'b1;
                        cmd.addr_sel = pti_pkg::ADDR_WR;
                        cmd.cnt_inc  = 1'b1;
                        cmd.res_sel  = pti_pkg::RES_ZERO;
                    end
                end
                else if (stat.op == pti_pkg::OP_CLEAR)
                begin
                    cmd.cnt_clr = 1'b1;
                    cmd.res_go  = 1'b1;
                    cmd.res_sel = pti_pkg::RES_ZERO;
                end
                else if (stat.n_zero)
                begin
                    cmd.res_go  = 1'b1;
                    cmd.res_sel = pti_pkg::RES_EMPTY;
                end
                else if (stat.op == pti_pkg::OP_LAST || stat.neg || stat.n_one)
                begin
                    // farthest point, negative distance or single point: read the last entry
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = pti_pkg::ADDR_LASTPT;
                    state_next   = S_PT_WAIT;
                end
                else
                begin
                    cmd.ram_re   = 1'b1;
                    cmd.addr_sel = pti_pkg::ADDR_FIRSTPT;
                    cmd.idx_init = 1'b1;
                    state_next   = S_FIRST_WAIT;
                end
            end
            S_PT_WAIT:
            begin
                cmd.res_go  = 1'b1;
                cmd.res_sel = pti_pkg::RES_RAM;
                state_next  = S_IDLE;
            end
            S_FIRST_WAIT:
            begin
                cmd.cap_first = 1'b1;
                state_next    = S_SRCH_RD;
            end
            S_SRCH_RD:
            begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = pti_pkg::ADDR_IDX;
                state_next   = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (stat.bracket)
                begin
                    cmd.cap_cur = 1'b1;
                    half_next   = 1'b0;
                    state_next  = S_MUL;
                end
                else if (stat.last_idx)
                begin
                    // no bracket: clamp to first or last point
                    cmd.res_go  = 1'b1;
                    cmd.res_sel = stat.at_first ? pti_pkg::RES_FIRST : pti_pkg::RES_RAM;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.cap_prev = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.lerp_save = 1'b1;
                if (half_reg)
                begin
                    cmd.res_go  = 1'b1;
                    cmd.res_sel = pti_pkg::RES_LERP;
                    state_next  = S_IDLE;
                end
                else
                begin
                    half_next  = 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/pti_datapath.sv
// ----------------------------------------------------------------------------
// pti_datapath
// Point counts, point RAM, search registers, multiplier and serial divider.
// ----------------------------------------------------------------------------
module pti_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pti_pkg::pti_cmd_t              cmd,
    output pti_pkg::pti_stat_t             stat,
    input  logic [1:0]                     opcode,
    input  logic [pti_pkg::TID_W-1:0]      table_id,
    input  logic signed [pti_pkg::VAL_W-1:0] distance,
    input  logic [pti_pkg::VAL_W-1:0]      coupling_in,
    input  logic [pti_pkg::VAL_W-1:0]      ground_in,
    output logic                           done,
    output logic [pti_pkg::VAL_W-1:0]      ground_out,
    output logic [pti_pkg::VAL_W-1:0]      coupling_out,
    output logic [1:0]                     status
);

    localparam int W = pti_pkg::VAL_W;

    // latched command word
    logic [1:0]                  op_reg;
    logic [pti_pkg::TID_W-1:0]   tid_reg;
    logic signed [W-1:0]         x_reg;
    logic [W-1:0]                cin_reg;
    logic [W-1:0]                gin_reg;

    logic [pti_pkg::CNT_W-1:0]   cnt_reg [pti_pkg::NUM_TABLES];
    logic [pti_pkg::TBL_W-1:0]   tsel;
    logic [pti_pkg::CNT_W-1:0]   n;
    logic [pti_pkg::IDX_W-1:0]   idx_reg;

    pti_pkg::point_t             first_reg, prev_reg, cur_reg, rdata, wpoint;
    logic [pti_pkg::ADDR_W-1:0]  base, addr;
    logic [pti_pkg::POINT_W-1:0] rdata_raw;

    // interpolation
    logic [W-1:0]   y1, y2, diff, dx;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   span_reg, y1_reg, avg_reg;
    logic           up_reg, eq_reg;
    logic [W-1:0]   rem_reg, quo_reg;
    logic [W:0]     rem_sh;
    logic [pti_pkg::DCNT_W-1:0] dcnt_reg;
    logic [W-1:0]   lerp_val, g_lerp_reg;

    logic           done_reg;
    logic [W-1:0]   g_out_reg, c_out_reg;
    logic [1:0]     st_reg;

    assign tsel = pti_pkg::TBL_W'(tid_reg);
    assign n    = cnt_reg[tsel];
    assign base = pti_pkg::ADDR_W'(tsel) * pti_pkg::ADDR_W'(pti_pkg::MAX_POINTS);

    always_comb
    begin
        case (cmd.addr_sel)
            pti_pkg::ADDR_WR:      addr = base + pti_pkg::ADDR_W'(n);
            pti_pkg::ADDR_LASTPT:  addr = base + pti_pkg::ADDR_W'(n - 1'b1);
            pti_pkg::ADDR_FIRSTPT: addr = base;
            default:               addr = base + pti_pkg::ADDR_W'(idx_reg);
        endcase
    end

    assign wpoint = '{d: x_reg, c: cin_reg, g: gin_reg};

    pti_ram #(
        .WIDTH(pti_pkg::POINT_W),
        .DEPTH(pti_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (addr),
        .wdata (wpoint),
        .re    (cmd.ram_re),
        .raddr (addr),
        .rdata (rdata_raw)
    );

    assign rdata = pti_pkg::point_t'(rdata_raw);

    // status toward the sequencer
    always_comb
    begin
        stat.op       = op_reg;
        stat.absent   = (32'(tid_reg) >= pti_pkg::NUM_TABLES);
        stat.n_zero   = (n == '0);
        stat.n_one    = (n == pti_pkg::CNT_W'(1));
        stat.n_full   = (n >= pti_pkg::CNT_W'(pti_pkg::MAX_POINTS));
        stat.neg      = x_reg[W-1];
        stat.bracket  = (prev_reg.d <= x_reg) && (x_reg <= rdata.d);
        stat.last_idx = ((pti_pkg::CNT_W'(idx_reg) + 1'b1) == n);
        stat.at_first = (x_reg <= first_reg.d);
        stat.div_last = (dcnt_reg == pti_pkg::DCNT_W'(W - 1));
    end

    // operand selection for the current half (ground first, then coupling)
    assign y1     = cmd.half ? prev_reg.c : prev_reg.g;
    assign y2     = cmd.half ? cur_reg.c  : cur_reg.g;
    assign diff   = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    assign dx     = W'(x_reg - prev_reg.d);
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign lerp_val = eq_reg ? avg_reg : (up_reg ? (y1_reg + quo_reg) : (y1_reg - quo_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pti_pkg::NUM_TABLES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg[tsel] <= n + 1'b1;
            end
            else if (cmd.cnt_clr)
            begin
                cnt_reg[tsel] <= '0;
            end
            done_reg <= cmd.res_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= opcode;
            tid_reg <= table_id;
            x_reg   <= distance;
            cin_reg <= coupling_in;
            gin_reg <= ground_in;
        end
        if (cmd.idx_init)
        begin
            idx_reg <= pti_pkg::IDX_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.cap_first)
        begin
            first_reg <= rdata;
            prev_reg  <= rdata;
        end
        else if (cmd.cap_prev)
        begin
            prev_reg <= rdata;
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= rdata;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= diff * dx;
            span_reg <= W'(cur_reg.d - prev_reg.d);
            y1_reg   <= y1;
            up_reg   <= (y2 >= y1);
            eq_reg   <= (cur_reg.d == prev_reg.d);
            avg_reg  <= W'(({1'b0, y1} + {1'b0, y2}) >> 1);
        end
        // restoring division: quotient fits in W bits, so high half < span
        if (cmd.div_init)
        begin
            rem_reg  <= prod_reg[2*W-1:W];
            quo_reg  <= prod_reg[W-1:0];
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, span_reg})
            begin
                rem_reg <= W'(rem_sh - {1'b0, span_reg});
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.lerp_save && !cmd.half)
        begin
            g_lerp_reg <= lerp_val;
        end
        if (cmd.res_go)
        begin
            case (cmd.res_sel)
                pti_pkg::RES_EMPTY:
                begin
                    g_out_reg <= '0;
                    c_out_reg <= '0;
                    st_reg    <= pti_pkg::ST_EMPTY;
                end
                pti_pkg::RES_FULL:
                begin
                    g_out_reg <= '0;
                    c_out_reg <= '0;
                    st_reg    <= pti_pkg::ST_FULL;
                end
                pti_pkg::RES_RAM:
                begin
                    g_out_reg <= rdata.g;
                    c_out_reg <= (op_reg == pti_pkg::OP_QUERY && x_reg[W-1]) ? '0 : rdata.c;
                    st_reg    <= pti_pkg::ST_OK;
                end
                pti_pkg::RES_FIRST:
                begin
                    g_out_reg <= first_reg.g;
                    c_out_reg <= first_reg.c;
                    st_reg    <= pti_pkg::ST_OK;
                end
                pti_pkg::RES_LERP:
                begin
                    g_out_reg <= g_lerp_reg;
                    c_out_reg <= lerp_val;
                    st_reg    <= pti_pkg::ST_OK;
                end
                default:
                begin
                    g_out_reg <= '0;
                    c_out_reg <= '0;
                    st_reg    <= pti_pkg::ST_OK;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign ground_out   = g_out_reg;
    assign coupling_out = c_out_reg;
    assign status       = st_reg;

endmodule

FILE: src/pwl_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// pwl_table_interpolator_unit
// Piecewise-linear capacitance tables with append, clear and lookup words.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode, table_id, distance, coupling_in and ground_in and raise
//   start; the word is taken at the clock edge where start is high and busy
//   is low. Hold off new words while busy is high.
//   Exactly one result word comes back per command: done is high for one
//   cycle with ground_out, coupling_out and status valid. The receiver
//   cannot stall, so capture it in that cycle.
// Sequence (from the cycle in which start is taken through the done cycle):
//   append, clear, empty or absent table: decode, then the result.
//   farthest point, negative distance, single point: one RAM read, then the result.
//   interpolating query over n points with no bracketing pair: the walk
//   does one RAM read and compare per pair, then clamps to the first or last
//   point. When pair k (k = 1..n-1) brackets the distance, the walk stops there
//   and runs two interpolations, each a 32x32 multiply, a 32-step restoring
//   divide and a final add, run one after the other.
//   busy drops in the done cycle; a new word may be taken at the edge that
//   ends it.
// Reset clears every table's point count, so all tables start empty; the
// point RAM needs no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module pwl_table_interpolator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     opcode,
    input  logic [pti_pkg::TID_W-1:0]      table_id,
    input  logic signed [pti_pkg::VAL_W-1:0] distance,
    input  logic [pti_pkg::VAL_W-1:0]      coupling_in,
    input  logic [pti_pkg::VAL_W-1:0]      ground_in,
    output logic                           done,
    output logic [pti_pkg::VAL_W-1:0]      ground_out,
    output logic [pti_pkg::VAL_W-1:0]      coupling_out,
    output logic [1:0]                     status
);

    pti_pkg::pti_cmd_t  cmd;
    pti_pkg::pti_stat_t stat;

    // sequencer: owns busy and all step decisions
    pti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // storage and arithmetic: counts, point RAM, multiplier, divider
    pti_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .table_id     (table_id),
        .distance     (distance),
        .coupling_in  (coupling_in),
        .ground_in    (ground_in),
        .done         (done),
        .ground_out   (ground_out),
        .coupling_out (coupling_out),
        .status       (status)
    );

endmodule

FILE: src/pti_checker.sv
// ----------------------------------------------------------------------------
// pti_checker
// Port-level checks of the interpolator's command and result words.
// ----------------------------------------------------------------------------
module pti_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [pti_pkg::VAL_W-1:0] ground_out,
    input logic [pti_pkg::VAL_W-1:0] coupling_out,
    input logic [1:0]                status
);

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != pti_pkg::ST_OK |-> ground_out == '0 && coupling_out == '0)
        else $error("nonzero values with error status");

endmodule

bind pwl_table_interpolator_unit pti_checker u_pti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .ground_out   (ground_out),
    .coupling_out (coupling_out),
    .status       (status)
);

FILE: tb/sv/pwl_table_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_table_interpolator_unit_tb
// Self-checking bench for the piecewise-linear capacitance table unit.
// A queue of command words feeds a bursty driver; a monitor captures every
// done word and compares it with a scoreboard model of the point tables.
// ----------------------------------------------------------------------------
module pwl_table_interpolator_unit_tb;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  tid;
        logic [31:0] dval;
        logic [31:0] cin;
        logic [31:0] gin;
    } cmd_word_t;

    typedef struct {
        logic [31:0] g;
        logic [31:0] c;
        logic [1:0]  st;
    } res_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [3:0]  table_id;
    logic signed [31:0] distance;
    logic [31:0] coupling_in;
    logic [31:0] ground_in;
    logic        done;
    logic [31:0] ground_out;
    logic [31:0] coupling_out;
    logic [1:0]  status;

    cmd_word_t cmd_queue[$];
    res_word_t expected_results[$];
    int        error_count;
    int        burst_left;
    int        gap_left;
    bit        hold_for_drain;
    bit        stim_done;

    // Scoreboard copy of the tables.
    int unsigned mdl_count[pti_pkg::NUM_TABLES];
    logic [31:0] mdl_dist[pti_pkg::NUM_TABLES][pti_pkg::MAX_POINTS];
    logic [31:0] mdl_coup[pti_pkg::NUM_TABLES][pti_pkg::MAX_POINTS];
    logic [31:0] mdl_gnd[pti_pkg::NUM_TABLES][pti_pkg::MAX_POINTS];

    pwl_table_interpolator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .table_id     (table_id),
        .distance     (distance),
        .coupling_in  (coupling_in),
        .ground_in    (ground_in),
        .done         (done),
        .ground_out   (ground_out),
        .coupling_out (coupling_out),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Interpolate one capacitance; truncate the quotient toward zero.
    function automatic logic [31:0] lerp_cap(longint x, longint x1, logic [31:0] y1,
                                             longint x2, logic [31:0] y2);
        logic [63:0] dx;
        logic [63:0] span;
        logic [63:0] q;
        if (x1 == x2)
            return 32'(({32'd0, y1} + {32'd0, y2}) >> 1);
        dx   = 64'(x - x1);
        span = 64'(x2 - x1);
        if (y2 >= y1)
        begin
            q = (64'(y2 - y1) * dx) / span;
            return 32'(64'(y1) + q);
        end
        q = (64'(y1 - y2) * dx) / span;
        return 32'(64'(y1) - q);
    endfunction

    // Advance the table model by one word and return the result it gives.
    function automatic res_word_t table_lookup(cmd_word_t w);
        res_word_t   r;
        int unsigned n;
        int unsigned t;
        longint      x;
        longint      a;
        longint      b;
        bit          found;
        r = '{32'd0, 32'd0, pti_pkg::ST_OK};
        t = w.tid;
        if (t >= pti_pkg::NUM_TABLES)
        begin
            r.st = pti_pkg::ST_EMPTY;
            return r;
        end
        n = mdl_count[t];
        if (w.op == pti_pkg::OP_APPEND)
        begin
            if (n >= pti_pkg::MAX_POINTS)
                r.st = pti_pkg::ST_FULL;
            else
            begin
                mdl_dist[t][n] = w.dval;
                mdl_coup[t][n] = w.cin;
                mdl_gnd[t][n]  = w.gin;
                mdl_count[t]   = n + 1;
            end
        end
        else if (w.op == pti_pkg::OP_CLEAR)
            mdl_count[t] = 0;
        else if (n == 0)
            r.st = pti_pkg::ST_EMPTY;
        else if (w.op == pti_pkg::OP_LAST)
        begin
            r.g = mdl_gnd[t][n-1];
            r.c = mdl_coup[t][n-1];
        end
        else
        begin
            x = longint'($signed(w.dval));
            found = 1'b0;
            if (x < 0)
                r.g = mdl_gnd[t][n-1];
            else if (n == 1)
            begin
                r.g = mdl_gnd[t][0];
                r.c = mdl_coup[t][0];
            end
            else
            begin
                for (int i = 0; i + 1 < n && !found; i++)
                begin
                    a = longint'($signed(mdl_dist[t][i]));
                    b = longint'($signed(mdl_dist[t][i+1]));
                    if (a <= x && x <= b)
                    begin
                        r.g = lerp_cap(x, a, mdl_gnd[t][i], b, mdl_gnd[t][i+1]);
                        r.c = lerp_cap(x, a, mdl_coup[t][i], b, mdl_coup[t][i+1]);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (x <= longint'($signed(mdl_dist[t][0])))
                    begin
                        r.g = mdl_gnd[t][0];
                        r.c = mdl_coup[t][0];
                    end
                    else
                    begin
                        r.g = mdl_gnd[t][n-1];
                        r.c = mdl_coup[t][n-1];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic cmd_word_t mk(logic [1:0] op, logic [3:0] tid, logic [31:0] d,
                                     logic [31:0] c, logic [31:0] g);
        cmd_word_t w;
        w.op = op; w.tid = tid; w.dval = d; w.cin = c; w.gin = g;
        return w;
    endfunction

    // Append one word to the pending queue.
    task automatic queue_word(cmd_word_t w);
        cmd_queue = {cmd_queue, w};
    endtask

    // Driver: bursts of words separated by random gaps. A word goes out with
    // start high and holds until the edge where busy is low takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            opcode      <= pti_pkg::OP_APPEND;
            table_id    <= '0;
            distance    <= '0;
            coupling_in <= '0;
            ground_in   <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (start && busy)
        begin
            // hold the word until taken
        end
        else
        begin
            if (start)
                expected_results = {expected_results,
                                    table_lookup(mk(opcode, table_id, distance,
                                                    coupling_in, ground_in))};
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_queue.size() == 0 || (hold_for_drain &&
                     (expected_results.size() != 0 || start || busy)))
                start <= 1'b0;
            else
            begin
                cmd_word_t w;
                w = cmd_queue.pop_front();
                start       <= 1'b1;
                opcode      <= w.op;
                table_id    <= w.tid;
                distance    <= w.dval;
                coupling_in <= w.cin;
                ground_in   <= w.gin;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    // pick the next burst length and a random gap, possibly none, before the next word
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
            end
        end
    end

    // Monitor: the unit cannot be stalled, so capture done words every cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result g=%h c=%h st=%0d", $time,
                         ground_out, coupling_out, status);
                error_count++;
            end
            else
            begin
                res_word_t e;
                e = expected_results.pop_front();
                if (ground_out !== e.g)
                begin
                    $display("%0t: ground_out expected %h actual %h", $time, e.g, ground_out);
                    error_count++;
                end
                if (coupling_out !== e.c)
                begin
                    $display("%0t: coupling_out expected %h actual %h", $time,
                             e.c, coupling_out);
                    error_count++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    error_count++;
                end
            end
        end
    end

    // Build a table: clear, append mostly ascending points, then query it.
    task automatic add_table_sequence(logic [3:0] tid);
        int          npts;
        int          nq;
        int          d;
        logic [31:0] dmax;
        npts = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
        queue_word(mk(pti_pkg::OP_CLEAR, tid, $urandom, $urandom, $urandom));
        d = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < npts; i++)
        begin
            queue_word(mk(pti_pkg::OP_APPEND, tid, d, $urandom, $urandom));
            // mostly ascending, sometimes repeated or stepped back
            case ($urandom_range(0, 9))
                0: d = d;
                1: d = d - $urandom_range(1, 5000);
                default: d = d + $urandom_range(1, 200000);
            endcase
        end
        dmax = d;
        nq = $urandom_range(2, 6);
        for (int i = 0; i < nq; i++)
            queue_word(mk(($urandom_range(0, 4) == 0) ? pti_pkg::OP_LAST : pti_pkg::OP_QUERY,
                          tid,
                          ($urandom_range(0, 5) == 0) ? $urandom
                              : $urandom_range(0, dmax + 10),
                          $urandom, $urandom));
    endtask

    initial
    begin
        cmd_word_t w;
        error_count    = 0;
        hold_for_drain = 1'b0;
        stim_done      = 1'b0;
        for (int t = 0; t < pti_pkg::NUM_TABLES; t++)
            mdl_count[t] = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tables, single point, equal distances, extremes, unsorted points.
        queue_word(mk(pti_pkg::OP_QUERY, 4'd0, 32'd5, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_LAST, 4'd15, 32'd0, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd1, 32'h7fff_ffff, 32'hffff_ffff,
                      32'hffff_ffff));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd1, 32'd0, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd1, 32'h8000_0000, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd2, 32'd100, 32'd10, 32'd21));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd2, 32'd100, 32'hffff_ffff, 32'hffff_fffe));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd2, 32'd100, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd3, 32'h8000_0000, 32'h0, 32'hffff_ffff));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd3, 32'h7fff_ffff, 32'hffff_ffff, 32'h0));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd3, 32'h7fff_fffe, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd3, 32'd1, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd4, 32'd50, 32'd1, 32'd2));
        queue_word(mk(pti_pkg::OP_APPEND, 4'd4, 32'd10, 32'd3, 32'd4));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd4, 32'd20, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd4, 32'd60, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_LAST, 4'd4, 32'd0, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_CLEAR, 4'd4, 32'd0, 32'd0, 32'd0));
        queue_word(mk(pti_pkg::OP_LAST, 4'd4, 32'd0, 32'd0, 32'd0));
        // fill a table past full
        for (int i = 0; i < pti_pkg::MAX_POINTS + 2; i++)
            queue_word(mk(pti_pkg::OP_APPEND, 4'd5, i * 1000, $urandom, $urandom));
        queue_word(mk(pti_pkg::OP_QUERY, 4'd5, 32'd31500, 32'd0, 32'd0));

        // Random: mostly table sequences (clear, append, query), some noise words.
        while (cmd_queue.size() < 750)
        begin
            if ($urandom_range(0, 3) != 0)
                add_table_sequence(4'($urandom_range(0, 15)));
            else
            begin
                w = mk(2'($urandom_range(0, 3)), 4'($urandom), $urandom, $urandom, $urandom);
                queue_word(w);
            end
        end

        // pause once until every outstanding result has come back
        wait (cmd_queue.size() < 400);
        hold_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !start && !busy);
        repeat (3) @(posedge clk);
        hold_for_drain = 1'b0;

        wait (cmd_queue.size() == 0);
        @(posedge clk);
        wait (!start && expected_results.size() == 0);
        repeat (150) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/pti_pkg.sv
src/pti_ram.sv
src/pti_ctrl.sv
src/pti_datapath.sv
src/pwl_table_interpolator_unit.sv
src/pti_checker.sv
tb/sv/pwl_table_interpolator_unit_tb.sv
